/* hw/rtl/morse_timing_decoder_defines.svh */
// Assertion macros for the checker file of the Morse timing decoder.
`ifndef MORSE_TIMING_DECODER_DEFINES_SVH
`define MORSE_TIMING_DECODER_DEFINES_SVH

// Same-cycle implication, clocked on clk, held off during reset.
`define MTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, held off during reset.
`define MTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mtd_pkg.sv */
package mtd_pkg;

  // Run timer width and the extended width that holds up to 14 dot lengths
  localparam int TimerW = 24;
  localparam int ExtW = TimerW + 4;
  localparam int QDepth = 4;
  localparam int QAw = 2;

  localparam logic [TimerW-1:0] TimerInit = TimerW'(2560);
  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
  localparam logic [ExtW-1:0] Dot3Init = ExtW'(3 * 2560);
  localparam logic [ExtW-1:0] Dot7Init = ExtW'(7 * 2560);
  localparam logic [ExtW-1:0] Dot14Init = ExtW'(14 * 2560);

  // Input operation codes
  localparam logic OpSample = 1'b0;
  localparam logic OpAdvance = 1'b1;

  // Symbol counter limits
  localparam logic [2:0] SymMax = 3'd5;
  localparam logic [2:0] SymOver = 3'd6;

  localparam logic [6:0] SpaceCode = 7'h20;
  localparam logic [7:0] ThreshInit = 8'd100;

  typedef enum logic [1:0] {
    PH_CAL  = 2'd0,
    PH_WAIT = 2'd1,
    PH_DEC  = 2'd2,
    PH_FIN  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       message_end;
  } result_t;

  // One queued transaction: one or two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } q_entry_t;

  function automatic logic [ExtW-1:0] absdiff(input logic [ExtW-1:0] a,
                                              input logic [ExtW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Map symbol count and dash bits (bit 0 = first symbol) to ASCII, 0 if unknown
  function automatic logic [6:0] lookup(input logic [2:0] cnt, input logic [4:0] bits);
    logic [6:0] c;
    c = 7'h00;
    case ({cnt, bits})
      {3'd1, 5'd0}:  c = 7'h45; // E
      {3'd1, 5'd1}:  c = 7'h54; // T
      {3'd2, 5'd2}:  c = 7'h41; // A
      {3'd2, 5'd0}:  c = 7'h49; // I
      {3'd2, 5'd3}:  c = 7'h4D; // M
      {3'd2, 5'd1}:  c = 7'h4E; // N
      {3'd3, 5'd1}:  c = 7'h44; // D
      {3'd3, 5'd3}:  c = 7'h47; // G
      {3'd3, 5'd5}:  c = 7'h4B; // K
      {3'd3, 5'd7}:  c = 7'h4F; // O
      {3'd3, 5'd2}:  c = 7'h52; // R
      {3'd3, 5'd0}:  c = 7'h53; // S
      {3'd3, 5'd4}:  c = 7'h55; // U
      {3'd3, 5'd6}:  c = 7'h57; // W
      {3'd4, 5'd1}:  c = 7'h42; // B
      {3'd4, 5'd5}:  c = 7'h43; // C
      {3'd4, 5'd4}:  c = 7'h46; // F
      {3'd4, 5'd0}:  c = 7'h48; // H
      {3'd4, 5'd14}: c = 7'h4A; // J
      {3'd4, 5'd2}:  c = 7'h4C; // L
      {3'd4, 5'd6}:  c = 7'h50; // P
      {3'd4, 5'd11}: c = 7'h51; // Q
      {3'd4, 5'd8}:  c = 7'h56; // V
      {3'd4, 5'd9}:  c = 7'h58; // X
      {3'd4, 5'd13}: c = 7'h59; // Y
      {3'd4, 5'd3}:  c = 7'h5A; // Z
      {3'd5, 5'd30}: c = 7'h31;
      {3'd5, 5'd28}: c = 7'h32;
      {3'd5, 5'd24}: c = 7'h33;
      {3'd5, 5'd16}: c = 7'h34;
      {3'd5, 5'd0}:  c = 7'h35;
      {3'd5, 5'd1}:  c = 7'h36;
      {3'd5, 5'd3}:  c = 7'h37;
      {3'd5, 5'd7}:  c = 7'h38;
      {3'd5, 5'd15}: c = 7'h39;
      {3'd5, 5'd31}: c = 7'h30;
      default:       c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/mtd_front.sv */
module mtd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [7:0]         in_intensity,
  input  logic [11:0]        in_frame_ticks,
  input  logic               q_full,
  output logic               q_push,
  output mtd_pkg::q_entry_t  q_wdata
);

  logic [7:0]                     thr_r;
  mtd_pkg::phase_t                phase_r, phase_nxt;
  logic                           led_r, led_nxt;
  logic [mtd_pkg::TimerW-1:0]     timer_r, timer_nxt;
  logic [mtd_pkg::TimerW-1:0]     dot_r, dot_nxt;
  logic [mtd_pkg::ExtW-1:0]       d3_r, d3_nxt, d7_r, d7_nxt, d14_r, d14_nxt;
  logic [2:0]                     cnt_r, cnt_nxt;
  logic [4:0]                     bits_r, bits_nxt;

  logic                           fire, now, dash;
  logic [mtd_pkg::ExtW-1:0]       t_ext, dsp, dlt, dwd, r_ext;
  logic [mtd_pkg::TimerW:0]       sum, rq_sum;
  logic [mtd_pkg::TimerW-1:0]     t_sat, r_q;
  logic                           sp_gap, lt_gap, end_hit, wait_go;
  logic [6:0]                     lk;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign now      = in_intensity > thr_r;

  // Gap and mark distances to 1, 3 and 7 dots
  assign t_ext = {4'b0, timer_r};
  assign dsp   = mtd_pkg::absdiff(t_ext, {4'b0, dot_r});
  assign dlt   = mtd_pkg::absdiff(t_ext, d3_r);
  assign dwd   = mtd_pkg::absdiff(t_ext, d7_r);

  assign sp_gap  = (dsp <= dlt) && (dsp <= dwd);
  assign lt_gap  = (dlt <= dsp) && (dlt <= dwd);
  assign end_hit = (phase_r == mtd_pkg::PH_DEC) && (t_ext > d14_r);
  assign wait_go = !led_r && ((dlt <= dsp) || (dwd <= dsp));
  assign dash    = !(dsp <= dlt);
  assign lk      = mtd_pkg::lookup(cnt_r, bits_r);

  // Saturating run timer advance
  assign sum   = {1'b0, timer_r} + {{(mtd_pkg::TimerW - 11){1'b0}}, in_frame_ticks};
  assign t_sat = sum[mtd_pkg::TimerW] ? mtd_pkg::TimerMax : sum[mtd_pkg::TimerW-1:0];

  // Round to nearest quarter second, ties down, clamp at timer max
  assign rq_sum = {1'b0, timer_r} + (mtd_pkg::TimerW + 1)'(31);
  assign r_q    = rq_sum[mtd_pkg::TimerW] ? mtd_pkg::TimerMax
                : {rq_sum[mtd_pkg::TimerW-1:6], 6'b0};
  assign r_ext  = {4'b0, r_q};

  // Phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (in_op == mtd_pkg::OpAdvance) begin
        if (phase_r == mtd_pkg::PH_CAL) phase_nxt = mtd_pkg::PH_WAIT;
      end else begin
        case (phase_r)
          mtd_pkg::PH_WAIT: begin
            if ((led_r != now) && wait_go) phase_nxt = mtd_pkg::PH_DEC;
          end
          mtd_pkg::PH_DEC: begin
            if (end_hit) phase_nxt = mtd_pkg::PH_FIN;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Sample datapath and result generation
  always_comb begin
    led_nxt   = led_r;
    timer_nxt = timer_r;
    dot_nxt   = dot_r;
    d3_nxt    = d3_r;
    d7_nxt    = d7_r;
    d14_nxt   = d14_r;
    cnt_nxt   = cnt_r;
    bits_nxt  = bits_r;
    q_push    = 1'b0;
    q_wdata   = '0;
    if (fire && (in_op == mtd_pkg::OpSample) && (phase_r != mtd_pkg::PH_FIN)) begin
      led_nxt = now;
      if (end_hit) begin
        // close the message with the pending letter
        q_push                 = 1'b1;
        q_wdata.r0.char_valid  = (lk != 7'h00);
        q_wdata.r0.char_code   = lk;
        q_wdata.r0.message_end = 1'b1;
        cnt_nxt                = 3'd0;
        bits_nxt               = 5'd0;
      end else if (phase_r == mtd_pkg::PH_CAL) begin
        if (led_r && now) begin
          timer_nxt = t_sat;
        end else begin
          if (led_r && (r_q < dot_r)) begin
            dot_nxt = r_q;
            d3_nxt  = r_ext + (r_ext << 1);
            d7_nxt  = (r_ext << 3) - r_ext;
            d14_nxt = ((r_ext << 3) - r_ext) << 1;
          end
          timer_nxt = '0;
        end
      end else if (led_r == now) begin
        timer_nxt = t_sat;
      end else begin
        timer_nxt = '0;
        if (phase_r == mtd_pkg::PH_DEC) begin
          if (led_r) begin
            // append dot or dash
            if (cnt_r < mtd_pkg::SymMax) begin
              bits_nxt = bits_r | (5'(dash) << cnt_r);
              cnt_nxt  = cnt_r + 3'd1;
            end else begin
              cnt_nxt = mtd_pkg::SymOver;
            end
          end else if (!sp_gap) begin
            // letter or word gap: flush the letter
            cnt_nxt  = 3'd0;
            bits_nxt = 5'd0;
            if (lk != 7'h00) begin
              q_push               = 1'b1;
              q_wdata.r0.char_valid = 1'b1;
              q_wdata.r0.char_code  = lk;
              if (!lt_gap) begin
                q_wdata.two           = 1'b1;
                q_wdata.r1.char_valid = 1'b1;
                q_wdata.r1.char_code  = mtd_pkg::SpaceCode;
              end
            end else if (!lt_gap) begin
              q_push                = 1'b1;
              q_wdata.r0.char_valid = 1'b1;
              q_wdata.r0.char_code  = mtd_pkg::SpaceCode;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= mtd_pkg::ThreshInit;
      phase_r <= mtd_pkg::PH_CAL;
      led_r   <= 1'b0;
      timer_r <= mtd_pkg::TimerInit;
      dot_r   <= mtd_pkg::TimerInit;
      d3_r    <= mtd_pkg::Dot3Init;
      d7_r    <= mtd_pkg::Dot7Init;
      d14_r   <= mtd_pkg::Dot14Init;
      cnt_r   <= 3'd0;
      bits_r  <= 5'd0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      phase_r <= phase_nxt;
      led_r   <= led_nxt;
      timer_r <= timer_nxt;
      dot_r   <= dot_nxt;
      d3_r    <= d3_nxt;
      d7_r    <= d7_nxt;
      d14_r   <= d14_nxt;
      cnt_r   <= cnt_nxt;
      bits_r  <= bits_nxt;
    end
  end

endmodule

/* hw/rtl/mtd_queue.sv */
module mtd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mtd_pkg::q_entry_t  wdata,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output mtd_pkg::q_entry_t  rdata
);

  mtd_pkg::q_entry_t        mem_r [mtd_pkg::QDepth];
  logic [mtd_pkg::QAw-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [mtd_pkg::QAw:0]    cnt_r, cnt_nxt;
  logic                     do_push, do_pop;

  assign full    = (cnt_r == (mtd_pkg::QAw + 1)'(mtd_pkg::QDepth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

endmodule

/* hw/rtl/mtd_back.sv */
module mtd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  mtd_pkg::q_entry_t  q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_char_valid,
  output logic [6:0]         out_char_code,
  output logic               out_message_end,
  output logic               out_last
);

  logic              valid_r, valid_nxt;
  logic              sel_r, sel_nxt;
  mtd_pkg::result_t  res_r, res_nxt;
  logic              last_r, last_nxt;
  logic              load, is_last;

  // Load the output register when it is free or being drained
  assign load    = (!valid_r || out_ready) && !q_empty;
  assign is_last = !q_rdata.two || sel_r;
  assign q_pop   = load && is_last;

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = sel_r ? q_rdata.r1 : q_rdata.r0;
      last_nxt  = is_last;
      sel_nxt   = !is_last;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_char_valid  = res_r.char_valid;
  assign out_char_code   = res_r.char_code;
  assign out_message_end = res_r.message_end;
  assign out_last        = last_r;

endmodule

/* hw/rtl/morse_timing_decoder.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | in_op, in_intensity, in_frame_ticks
// out      | out_valid / out_ready| out_char_valid, out_char_code,
//          |                      | out_message_end, out_last
// cfg      | cfg_wr_en            | cfg_wr_data (on_threshold)
//
// One input transaction is taken every cycle while the 4-entry result queue
// has room; the classifier finishes a sample in that same cycle.
// A transaction yields up to two results, drained one per cycle (while
// out_ready is high) from the queue through a registered output stage; the
// first result is offered on out_valid after the queue and the output register.
// Synchronous active-low reset; input stalls only when the queue is full.
module morse_timing_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_intensity,
  input  logic [11:0] in_frame_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_char_valid,
  output logic [6:0]  out_char_code,
  output logic        out_message_end,
  output logic        out_last
);

  logic               q_push, q_full, q_pop, q_empty;
  mtd_pkg::q_entry_t  q_wdata, q_rdata;

  mtd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_intensity   (in_intensity),
    .in_frame_ticks (in_frame_ticks),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  mtd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  mtd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_valid  (out_char_valid),
    .out_char_code   (out_char_code),
    .out_message_end (out_message_end),
    .out_last        (out_last)
  );

endmodule

/* hw/rtl/mtd_checker.sv */
`include "morse_timing_decoder_defines.svh"

module mtd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_char_valid,
  input logic [6:0]  out_char_code,
  input logic        out_message_end,
  input logic        out_last
);

  // A stalled result transaction stays offered
  `MTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

  // No character means a zero code
  `MTD_ASSERT_NOW(a_code_zero, out_valid && !out_char_valid, out_char_code == 7'h00, "stray code")

  // Message end always closes its input's results
  `MTD_ASSERT_NOW(a_end_last, out_valid && out_message_end, out_last, "message end not last")

  // Nothing follows the message end
  `MTD_ASSERT_NEXT(a_end_quiet, out_valid && out_ready && out_message_end, !out_valid, "late result")

endmodule

bind morse_timing_decoder mtd_checker u_mtd_checker (.*);
